FILE: sv/sfr_pkg.sv
package sfr_pkg;

	localparam int LENGTH_BITS_DEF = 16;

	localparam logic [7:0] FLAG_BYTE  = 8'h7E;
	localparam logic [7:0] ESC_BYTE   = 8'h7D;
	localparam logic [7:0] ESC_MASK   = 8'h20;
	localparam logic [7:0] CTRL_SEQ0  = 8'h00;
	localparam logic [7:0] CTRL_SEQ1  = 8'h40;
	localparam logic [7:0] ADDR_RESET = 8'h03;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	localparam logic [1:0] RESP_RR0  = 2'd0;
	localparam logic [1:0] RESP_RR1  = 2'd1;
	localparam logic [1:0] RESP_REJ0 = 2'd2;
	localparam logic [1:0] RESP_REJ1 = 2'd3;

	typedef struct packed {
		logic        kind;
		logic [7:0]  payload_byte;
		logic        accepted;
		logic [1:0]  code;
		logic        sequence_bit;
		logic [15:0] length;
		logic        saturated;
	} result_t;

endpackage

FILE: sv/sfr_parser.sv
module sfr_parser import sfr_pkg::*; #(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] byte_s1,
	input  logic [7:0] frame_address,
	output logic       res_valid,
	output result_t    res
);

	localparam logic [2:0] PH_HUNT = 3'd0;
	localparam logic [2:0] PH_ADDR = 3'd1;
	localparam logic [2:0] PH_CTRL = 3'd2;
	localparam logic [2:0] PH_HCHK = 3'd3;
	localparam logic [2:0] PH_DATA = 3'd4;
	localparam logic [2:0] PH_ESC  = 3'd5;

	localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

	logic [2:0]             phase_q, phase_d;
	logic                   cap_seq_q, cap_seq_d;
	logic                   exp_seq_q, exp_seq_d;
	logic [7:0]             held_q, held_d;
	logic                   held_valid_q, held_valid_d;
	logic [7:0]             check_q, check_d;
	logic [LENGTH_BITS-1:0] len_q, len_d;

	logic [7:0] data_in;
	logic       take;
	logic       chk_ok;
	logic       seq_match;
	logic [7:0] hdr_check;

	assign hdr_check = frame_address ^ (cap_seq_q ? CTRL_SEQ1 : CTRL_SEQ0);
	assign chk_ok    = held_valid_q && (check_q == 8'h00);
	assign seq_match = (cap_seq_q == exp_seq_q);
	assign data_in   = (phase_q == PH_ESC) ? (byte_s1 ^ ESC_MASK) : byte_s1;

	always_comb begin
		phase_d      = phase_q;
		cap_seq_d    = cap_seq_q;
		exp_seq_d    = exp_seq_q;
		held_d       = held_q;
		held_valid_d = held_valid_q;
		check_d      = check_q;
		len_d        = len_q;
		take         = 1'b0;
		res_valid    = 1'b0;
		res          = '0;
		unique case (phase_q)
			PH_HUNT: begin
				if (byte_s1 == FLAG_BYTE) phase_d = PH_ADDR;
			end
			PH_ADDR: begin
				priority if (byte_s1 == frame_address) phase_d = PH_CTRL;
				else if (byte_s1 != FLAG_BYTE) phase_d = PH_HUNT;
				else phase_d = PH_ADDR;
			end
			PH_CTRL: begin
				priority if (byte_s1 == CTRL_SEQ0 || byte_s1 == CTRL_SEQ1) begin
					cap_seq_d = (byte_s1 == CTRL_SEQ1);
					phase_d   = PH_HCHK;
				end else if (byte_s1 == FLAG_BYTE) begin
					phase_d = PH_ADDR;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_HCHK: begin
				priority if (byte_s1 == hdr_check) begin
					phase_d      = PH_DATA;
					held_d       = 8'h00;
					held_valid_d = 1'b0;
					check_d      = 8'h00;
					len_d        = '0;
				end else if (byte_s1 == FLAG_BYTE) begin
					phase_d = PH_ADDR;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_DATA: begin
				priority if (byte_s1 == FLAG_BYTE) begin
					phase_d          = PH_ADDR;
					res_valid        = 1'b1;
					res.kind         = KIND_VERDICT;
					res.sequence_bit = cap_seq_q;
					res.length       = 16'(len_q);
					res.saturated    = (len_q == LEN_MAX);
					priority if (chk_ok && seq_match) begin
						res.accepted = 1'b1;
						res.code     = exp_seq_q ? RESP_RR0 : RESP_RR1;
						exp_seq_d    = ~exp_seq_q;
					end else if (seq_match) begin
						res.code = exp_seq_q ? RESP_REJ1 : RESP_REJ0;
					end else begin
						res.code = exp_seq_q ? RESP_RR1 : RESP_RR0;
					end
				end else if (byte_s1 == ESC_BYTE) begin
					phase_d = PH_ESC;
				end else begin
					take = 1'b1;
				end
			end
			PH_ESC: begin
				phase_d = PH_DATA;
				take    = 1'b1;
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
		if (take) begin
			if (held_valid_q) begin
				res_valid        = 1'b1;
				res.kind         = KIND_PAYLOAD;
				res.payload_byte = held_q;
				if (len_q != LEN_MAX) len_d = len_q + LENGTH_BITS'(1);
			end
			held_d       = data_in;
			held_valid_d = 1'b1;
			check_d      = check_q ^ data_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HUNT;
			cap_seq_q    <= 1'b0;
			exp_seq_q    <= 1'b0;
			held_q       <= 8'h00;
			held_valid_q <= 1'b0;
			check_q      <= 8'h00;
			len_q        <= '0;
		end else if (step) begin
			phase_q      <= phase_d;
			cap_seq_q    <= cap_seq_d;
			exp_seq_q    <= exp_seq_d;
			held_q       <= held_d;
			held_valid_q <= held_valid_d;
			check_q      <= check_d;
			len_q        <= len_d;
		end
	end

endmodule

FILE: sv/sfr_out_reg.sv
module sfr_out_reg import sfr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t res,
	input  logic    out_ready,
	output logic    out_valid,
	output result_t out_res
);

	logic    valid_q;
	result_t res_q;

	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) res_q <= res;
	end

endmodule

FILE: sv/stuffed_frame_receiver_stop_and_wait_unit.sv
// Stop-and-wait receiver for byte-stuffed frames. Takes one raw line byte per
// transfer on rx_byte and can accept a byte every clock cycle unless the output
// stalls. Each byte lands in an input register, passes combinational deframing
// logic and reaches the output register, which offers its result on out_valid.
// A result waiting on out_ready holds the byte behind it and stalls the input.
// A byte yields at most one result: a destuffed payload byte (result_kind 0,
// sent one byte late since the last byte before the closing flag is the check)
// or an end-of-frame verdict (result_kind 1) with accept, RR/REJ response code,
// frame sequence bit and saturating payload length. Headers, escapes and
// repeated flags produce nothing. frame_address sits at APB byte address 0.
module stuffed_frame_receiver_stop_and_wait_unit import sfr_pkg::*; #(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        result_kind,
	output logic [7:0]  payload_byte,
	output logic        frame_accepted,
	output logic [1:0]  response_code,
	output logic        frame_sequence,
	output logic [15:0] payload_length,
	output logic        length_saturated
);

	logic [7:0] addr_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;
	logic       step;
	logic       res_valid;
	result_t    res;
	result_t    out_res;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {24'h0, addr_q} : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= ADDR_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
			addr_q <= pwdata[7:0];
		end
	end

	assign advance  = !out_valid || out_ready;
	assign step     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) byte_s1 <= rx_byte;
	end

	sfr_parser #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.byte_s1      (byte_s1),
		.frame_address(addr_q),
		.res_valid    (res_valid),
		.res          (res)
	);

	sfr_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (step && res_valid),
		.res      (res),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.out_res  (out_res)
	);

	assign result_kind      = out_res.kind;
	assign payload_byte     = out_res.payload_byte;
	assign frame_accepted   = out_res.accepted;
	assign response_code    = out_res.code;
	assign frame_sequence   = out_res.sequence_bit;
	assign payload_length   = out_res.length;
	assign length_saturated = out_res.saturated;

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output register");

	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_PAYLOAD |->
			!frame_accepted && response_code == RESP_RR0 && !frame_sequence &&
			payload_length == 16'h0 && !length_saturated)
		else $error("payload result carries verdict fields");

	a_verdict_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_VERDICT |-> payload_byte == 8'h00)
		else $error("verdict carries payload byte");

	a_accept_is_rr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_accepted |->
			(response_code == RESP_RR0 || response_code == RESP_RR1) &&
			response_code[0] != frame_sequence)
		else $error("accepted frame without RR of next sequence");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import sfr_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int DIRECTED_ROWS = 28;
	localparam int ADDRESS_PHASES = 7;
	localparam int PHASE_BYTES = 270;
	localparam int REPORT_MAX = 10;
	localparam int SQUEEZE_AT = 400;
	localparam int SQUEEZE_CYCLES = 400;
	localparam int DRAIN_CYCLES = 8;
	localparam logic [2:0] ADDR_REG = 3'd0;
	localparam int unsigned COUNT_MAX = (1 << LENGTH_BITS_DEF) - 1;

	typedef enum logic [2:0] {
		SEEK_FLAG,
		SEEK_ADDR,
		SEEK_CTRL,
		SEEK_HDR_CHK,
		IN_BODY,
		AFTER_ESC
	} rx_phase_t;

	typedef struct packed {
		logic [7:0] value;
		logic       typed;
		result_t    want;
	} line_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  rx_byte = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        result_kind;
	logic [7:0]  payload_byte;
	logic        frame_accepted;
	logic [1:0]  response_code;
	logic        frame_sequence;
	logic [15:0] payload_length;
	logic        length_saturated;

	stuffed_frame_receiver_stop_and_wait_unit dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	logic [7:0]  addr_cfg = ADDR_RESET;
	rx_phase_t   rx_phase = SEEK_FLAG;
	logic        seq_seen = 1'b0;
	logic        seq_due = 1'b0;
	logic [7:0]  held = '0;
	logic        held_ok = 1'b0;
	logic [7:0]  body_xor = '0;
	int unsigned body_len = 0;

	line_item_t line_q[$];
	result_t    due_results[$];
	line_item_t cur_item = '0;

	int  queued_count = 0;
	int  taken_count = 0;
	int  gap_left = 0;
	int  send_clean = 0;
	int  stall_left = 0;
	int  recv_clean = 0;
	bit  squeezed = 1'b0;
	int  cycle_count = 0;
	int  problems = 0;
	int  settings_done = 0;
	int  payload_seen = 0;
	int  verdict_seen = 0;
	int  accepted_seen = 0;
	int  saturated_seen = 0;

	function automatic bit take_body(input logic [7:0] d, output result_t r);
		bit got;
		r = '0;
		got = 1'b0;
		if (held_ok) begin
			r.kind = KIND_PAYLOAD;
			r.payload_byte = held;
			got = 1'b1;
			if (body_len < COUNT_MAX)
				body_len++;
		end
		held = d;
		held_ok = 1'b1;
		body_xor ^= d;
		return got;
	endfunction

	function automatic bit deframe(input logic [7:0] b, output result_t r);
		logic [7:0] ctl;
		bit ok, hit;
		r = '0;
		case (rx_phase)
		SEEK_FLAG: begin
			if (b == FLAG_BYTE)
				rx_phase = SEEK_ADDR;
		end
		SEEK_ADDR: begin
			if (b == addr_cfg)
				rx_phase = SEEK_CTRL;
			else if (b != FLAG_BYTE)
				rx_phase = SEEK_FLAG;
		end
		SEEK_CTRL: begin
			if (b == CTRL_SEQ0 || b == CTRL_SEQ1) begin
				seq_seen = (b == CTRL_SEQ1);
				rx_phase = SEEK_HDR_CHK;
			end else if (b == FLAG_BYTE) begin
				rx_phase = SEEK_ADDR;
			end else begin
				rx_phase = SEEK_FLAG;
			end
		end
		SEEK_HDR_CHK: begin
			ctl = seq_seen ? CTRL_SEQ1 : CTRL_SEQ0;
			if (b == (addr_cfg ^ ctl)) begin
				rx_phase = IN_BODY;
				held = '0;
				held_ok = 1'b0;
				body_xor = '0;
				body_len = 0;
			end else if (b == FLAG_BYTE) begin
				rx_phase = SEEK_ADDR;
			end else begin
				rx_phase = SEEK_FLAG;
			end
		end
		IN_BODY: begin
			if (b == FLAG_BYTE) begin
				ok = held_ok && body_xor == 8'h00;
				hit = seq_seen == seq_due;
				r.kind = KIND_VERDICT;
				r.sequence_bit = seq_seen;
				r.length = body_len[15:0];
				r.saturated = body_len >= COUNT_MAX;
				if (ok && hit) begin
					r.accepted = 1'b1;
					r.code = seq_due ? RESP_RR0 : RESP_RR1;
					seq_due = !seq_due;
				end else if (hit) begin
					r.code = seq_due ? RESP_REJ1 : RESP_REJ0;
				end else begin
					r.code = seq_due ? RESP_RR1 : RESP_RR0;
				end
				rx_phase = SEEK_ADDR;
				return 1'b1;
			end else if (b == ESC_BYTE) begin
				rx_phase = AFTER_ESC;
			end else begin
				return take_body(b, r);
			end
		end
		AFTER_ESC: begin
			rx_phase = IN_BODY;
			return take_body(b ^ ESC_MASK, r);
		end
		default: begin
			rx_phase = SEEK_FLAG;
		end
		endcase
		return 1'b0;
	endfunction

	function automatic int unsigned pause_len();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic int unsigned send_gap();
		if (send_clean > 0) begin
			send_clean--;
			return 0;
		end
		if ($urandom_range(0, 99) < 3) begin
			send_clean = $urandom_range(30, 120);
			return 0;
		end
		if ($urandom_range(0, 99) < 60)
			return 0;
		return pause_len();
	endfunction

	function automatic string show(input result_t r);
		return $sformatf("kind=%0d byte=%02h acc=%0d code=%0d seq=%0d len=%0d sat=%0d",
			r.kind, r.payload_byte, r.accepted, r.code, r.sequence_bit, r.length, r.saturated);
	endfunction

	task automatic flag_problem(input string msg);
		problems++;
		if (problems <= REPORT_MAX)
			$display("ERROR at %0t: %s", $realtime, msg);
	endtask

	always @(posedge clk) begin : line_sender
		result_t r;
		bit got;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				taken_count++;
				got = deframe(rx_byte, r);
				if (cur_item.typed)
					due_results.push_back(cur_item.want);
				else if (got)
					due_results.push_back(r);
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (line_q.size() != 0) begin
					cur_item = line_q.pop_front();
					rx_byte <= cur_item.value;
					in_valid <= 1'b1;
					gap_left <= send_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : result_sink
		if (arst_n) begin
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_ready <= 1'b0;
			end else if (!squeezed && taken_count >= SQUEEZE_AT) begin
				squeezed <= 1'b1;
				stall_left <= SQUEEZE_CYCLES - 1;
				out_ready <= 1'b0;
			end else if (recv_clean > 0) begin
				recv_clean <= recv_clean - 1;
				out_ready <= 1'b1;
			end else if ($urandom_range(0, 99) < 2) begin
				recv_clean <= $urandom_range(40, 150);
				out_ready <= 1'b1;
			end else if ($urandom_range(0, 99) < 15) begin
				stall_left <= pause_len() - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : result_check
		result_t got, want;
		string bad;
		if (arst_n && out_valid && out_ready) begin
			got = {result_kind, payload_byte, frame_accepted, response_code, frame_sequence,
				payload_length, length_saturated};
			if (due_results.size() == 0) begin
				flag_problem({"unexpected result: ", show(got)});
			end else begin
				want = due_results.pop_front();
				bad = "";
				if (got.kind !== want.kind) bad = {bad, " result_kind"};
				if (got.payload_byte !== want.payload_byte) bad = {bad, " payload_byte"};
				if (got.accepted !== want.accepted) bad = {bad, " frame_accepted"};
				if (got.code !== want.code) bad = {bad, " response_code"};
				if (got.sequence_bit !== want.sequence_bit) bad = {bad, " frame_sequence"};
				if (got.length !== want.length) bad = {bad, " payload_length"};
				if (got.saturated !== want.saturated) bad = {bad, " length_saturated"};
				if (bad != "")
					flag_problem({"mismatch in", bad, ": expected ", show(want), ", got ",
						show(got)});
				if (want.kind == KIND_VERDICT) begin
					verdict_seen++;
					if (want.accepted) accepted_seen++;
					if (want.saturated) saturated_seen++;
				end else begin
					payload_seen++;
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL stuffed_frame_receiver_stop_and_wait_unit");
			$finish;
		end
	end

	task automatic apb_write(input logic [2:0] a, input logic [31:0] d);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= a;
		pwdata <= d;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic apb_read(input logic [2:0] a, output logic [31:0] d);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= a;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		d = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic verify_address(input logic [7:0] a);
		logic [31:0] back;
		apb_read(ADDR_REG, back);
		if (back !== {24'd0, a})
			flag_problem($sformatf("frame_address reads %08h, expected %08h", back, {24'd0, a}));
	endtask

	task automatic set_address(input logic [7:0] a);
		apb_write(ADDR_REG, {24'd0, a});
		addr_cfg = a;
		settings_done++;
		verify_address(a);
	endtask

	task automatic queue_item(input line_item_t it);
		line_q.push_back(it);
		queued_count++;
	endtask

	function automatic line_item_t plain(input logic [7:0] b);
		line_item_t it;
		it = '0;
		it.value = b;
		return it;
	endfunction

	function automatic line_item_t typed_row(input logic [7:0] b, input result_t r);
		line_item_t it;
		it = plain(b);
		it.typed = 1'b1;
		it.want = r;
		return it;
	endfunction

	function automatic result_t verdict(input logic acc, input logic [1:0] code, input logic sq,
		input logic [15:0] len);
		result_t r;
		r = '0;
		r.kind = KIND_VERDICT;
		r.accepted = acc;
		r.code = code;
		r.sequence_bit = sq;
		r.length = len;
		return r;
	endfunction

	function automatic line_item_t directed_row(input int i);
		case (i)
		0, 1, 20: return plain(FLAG_BYTE);
		2, 6, 16, 23: return plain(ADDR_RESET);
		3, 7, 17: return plain(CTRL_SEQ0);
		4, 8, 18: return plain(ADDR_RESET ^ CTRL_SEQ0);
		5: return typed_row(FLAG_BYTE, verdict(1'b0, RESP_REJ0, 1'b0, 16'd0));
		9: return plain(8'hFF);
		10, 12, 19: return plain(ESC_BYTE);
		11, 21: return plain(FLAG_BYTE ^ ESC_MASK);
		13: return plain(ESC_BYTE ^ ESC_MASK);
		// check over FF 7E 7D
		14: return plain(8'hFC);
		15: return typed_row(FLAG_BYTE, verdict(1'b1, RESP_RR1, 1'b0, 16'd3));
		22: return typed_row(FLAG_BYTE, verdict(1'b0, RESP_RR1, 1'b0, 16'd1));
		24: return plain(CTRL_SEQ1);
		25: return plain(ADDR_RESET ^ CTRL_SEQ1);
		26: return plain(8'h12);
		default: return typed_row(FLAG_BYTE, verdict(1'b0, RESP_REJ1, 1'b1, 16'd0));
		endcase
	endfunction

	task automatic push_byte(input logic [7:0] b);
		queue_item(plain(b));
	endtask

	task automatic push_stuffed(input logic [7:0] b);
		if (b == FLAG_BYTE || b == ESC_BYTE || $urandom_range(0, 19) == 0) begin
			push_byte(ESC_BYTE);
			push_byte(b ^ ESC_MASK);
		end else begin
			push_byte(b);
		end
	endtask

	task automatic append_frame();
		logic [7:0] ctl, b, chk_sum;
		int n, i, roll;
		roll = $urandom_range(0, 99);
		if (roll < 6) begin
			n = $urandom_range(1, 6);
			for (i = 0; i < n; i++)
				push_byte(8'($urandom_range(0, 255)));
			return;
		end
		if ($urandom_range(0, 3) != 0)
			push_byte(FLAG_BYTE);
		if ($urandom_range(0, 9) == 0)
			push_byte(FLAG_BYTE);
		push_byte($urandom_range(0, 9) != 0 ? addr_cfg : 8'($urandom_range(0, 255)));
		ctl = $urandom_range(0, 1) ? CTRL_SEQ1 : CTRL_SEQ0;
		if ($urandom_range(0, 19) == 0)
			push_byte($urandom_range(0, 1) ? FLAG_BYTE : 8'($urandom_range(0, 255)));
		else
			push_byte(ctl);
		push_byte($urandom_range(0, 14) != 0 ? addr_cfg ^ ctl : 8'($urandom_range(0, 255)));
		roll = $urandom_range(0, 99);
		if (roll < 10)
			n = -1;
		else if (roll < 85)
			n = $urandom_range(0, 12);
		else
			n = $urandom_range(13, 48);
		chk_sum = '0;
		for (i = 0; i < n; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 15)
				b = FLAG_BYTE;
			else if (roll < 27)
				b = ESC_BYTE;
			else
				b = 8'($urandom_range(0, 255));
			chk_sum ^= b;
			push_stuffed(b);
		end
		if (n >= 0)
			push_stuffed($urandom_range(0, 7) != 0 ? chk_sum : chk_sum ^ 8'($urandom_range(1, 255)));
		if ($urandom_range(0, 19) != 0)
			push_byte(FLAG_BYTE);
	endtask

	task automatic settle();
		int waited;
		while (taken_count != queued_count)
			@(negedge clk);
		waited = 0;
		while (due_results.size() != 0 && waited < 2000) begin
			@(negedge clk);
			waited++;
		end
		if (due_results.size() != 0) begin
			flag_problem($sformatf("%0d expected results never arrived", due_results.size()));
			due_results.delete();
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin : run
		int i, p, start;
		logic [7:0] a;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		verify_address(ADDR_RESET);
		set_address(ADDR_RESET);

		for (i = 0; i < DIRECTED_ROWS; i++)
			queue_item(directed_row(i));
		settle();

		for (p = 0; p < ADDRESS_PHASES; p++) begin
			case (p)
			0: a = 8'h00;
			1: a = 8'hFF;
			2: a = FLAG_BYTE;
			3: a = ESC_BYTE;
			default: a = 8'($urandom_range(0, 255));
			endcase
			set_address(a);
			start = queued_count;
			while (queued_count - start < PHASE_BYTES)
				append_frame();
			settle();
		end

		$display("Sent %0d line bytes under %0d address settings, %0d payload bytes checked.",
			taken_count, settings_done, payload_seen);
		$display("Checked %0d frame verdicts: %0d accepted, %0d with saturated length.",
			verdict_seen, accepted_seen, saturated_seen);
		if (problems == 0)
			$display("PASS stuffed_frame_receiver_stop_and_wait_unit");
		else
			$display("FAIL stuffed_frame_receiver_stop_and_wait_unit");
		$finish;
	end

endmodule

FILE: sim.f
sv/sfr_pkg.sv
sv/sfr_parser.sv
sv/sfr_out_reg.sv
sv/stuffed_frame_receiver_stop_and_wait_unit.sv
tb/sv/testbench.sv
